>>> sv/cdml_pkg.sv
// cdml_pkg: shared types and constants for the card-detect mount lifecycle block
// no dependencies; compiled first
package cdml_pkg;

  localparam int DELAY_W    = 16;
  localparam int SAMPLES_W  = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [DELAY_W-1:0]   DEFAULT_INSERTION_DELAY  = 16'd100;
  localparam logic [SAMPLES_W-1:0] DEFAULT_REQUIRED_SAMPLES = 4'd3;

  typedef enum logic {
    REG_INSERTION_DELAY  = 1'b0,
    REG_REQUIRED_SAMPLES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DELAY_W-1:0]   insertion_delay_ms;
    logic [SAMPLES_W-1:0] required_samples;
  } cfg_t;

  typedef struct packed {
    logic mount_attempt;
    logic logging_started;
    logic logging_stopped;
    logic unmount_attempt;
    logic is_mounted;
    logic settled_present;
  } result_t;

endpackage

>>> sv/cdml_cmd_if.sv
// cdml_cmd_if: input channel, one poll or start word per handshake
// standalone; width follows TIME_BITS
interface cdml_cmd_if #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [TIME_BITS-1:0] now_ms;
  logic                 card_present;
  logic                 mount_ok;
  logic                 unmount_ok;

  modport source (
    output valid, operation, now_ms, card_present, mount_ok, unmount_ok,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, card_present, mount_ok, unmount_ok,
    output ready
  );
endinterface

>>> sv/cdml_rsp_if.sv
// cdml_rsp_if: result channel, one event and status word per handshake
// standalone
interface cdml_rsp_if;
  logic valid;
  logic ready;
  logic mount_attempt;
  logic logging_started;
  logic logging_stopped;
  logic unmount_attempt;
  logic is_mounted;
  logic settled_present;

  modport source (
    output valid, mount_attempt, logging_started, logging_stopped, unmount_attempt,
           is_mounted, settled_present,
    input  ready
  );
  modport sink (
    input  valid, mount_attempt, logging_started, logging_stopped, unmount_attempt,
           is_mounted, settled_present,
    output ready
  );
endinterface

>>> sv/cdml_regs.sv
// cdml_regs: apb configuration registers (insertion delay, required samples)
// depends on cdml_pkg
module cdml_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cdml_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cdml_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cdml_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output cdml_pkg::cfg_t                   cfg
);
  import cdml_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.insertion_delay_ms <= DEFAULT_INSERTION_DELAY;
      cfg.required_samples   <= DEFAULT_REQUIRED_SAMPLES;
    end else if (wr_en) begin
      unique case (idx)
        REG_INSERTION_DELAY:  cfg.insertion_delay_ms <= pwdata[DELAY_W-1:0];
        REG_REQUIRED_SAMPLES: cfg.required_samples   <= pwdata[SAMPLES_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INSERTION_DELAY:
        prdata = {{(APB_DATA_W-DELAY_W){1'b0}}, cfg.insertion_delay_ms};
      REG_REQUIRED_SAMPLES:
        prdata = {{(APB_DATA_W-SAMPLES_W){1'b0}}, cfg.required_samples};
    endcase
  end

endmodule

>>> sv/cdml_rem.sv
// cdml_rem: remainder of a time difference by the sample period
// standalone; eight dividend bits per cycle by reciprocal multiplication
module cdml_rem #(
  parameter int TIME_BITS = 48,
  parameter int DIVISOR   = 200
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 clear,
  input  logic [TIME_BITS-1:0]                 dividend,
  output logic                                 busy,
  output logic                                 done,
  output logic [$clog2(DIVISOR+1)-1:0]         rem
);
  localparam int RW    = $clog2(DIVISOR + 1);
  localparam int DW    = 8;
  localparam int NSTEP = (TIME_BITS + DW - 1) / DW;
  localparam int PW    = NSTEP * DW;
  localparam int VW    = RW + DW;
  localparam int LW    = $clog2(DIVISOR);
  localparam int SH    = VW + LW;
  localparam int MW    = VW + 2;
  localparam int PRW   = VW + MW;
  localparam int CW    = $clog2(NSTEP + 1);
  localparam logic [63:0] MUL64 =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MUL   = MW'(MUL64);
  localparam logic [VW-1:0] DIV_V = VW'(DIVISOR);

  logic [PW-1:0]  shreg;
  logic [CW-1:0]  cnt;
  logic [VW-1:0]  val;
  logic [PRW-1:0] prod;
  logic [DW-1:0]  quo;
  logic [VW-1:0]  val_sub;
  logic [RW-1:0]  rem_next;

  // partial remainder times 256 plus the next dividend byte, reduced by the period
  always_comb begin
    val      = {rem, shreg[PW-1 -: DW]};
    prod     = PRW'(val) * PRW'(MUL);
    quo      = prod[SH +: DW];
    val_sub  = val - VW'(quo) * DIV_V;
    rem_next = val_sub[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (clear) begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= PW'(dividend);
      rem   <= '0;
      cnt   <= CW'(NSTEP);
    end else if (busy) begin
      shreg <= shreg << DW;
      rem   <= rem_next;
      cnt   <= cnt - CW'(1);
    end
  end

endmodule

>>> sv/cdml_lifecycle.sv
// cdml_lifecycle: lifecycle state and single-pass update for one word
// depends on cdml_pkg and cdml_rem
module cdml_lifecycle #(
  parameter int TIME_BITS        = 48,
  parameter int SAMPLE_PERIOD_MS = 200
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  operation,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  logic                  card_present,
  input  logic                  mount_ok,
  input  logic                  unmount_ok,
  input  cdml_pkg::cfg_t        cfg,
  input  logic                  fire,
  output logic                  item_done,
  output cdml_pkg::result_t     result
);
  import cdml_pkg::*;

  localparam int RW = $clog2(SAMPLE_PERIOD_MS + 1);
  localparam logic [TIME_BITS-1:0] PERIOD = TIME_BITS'(SAMPLE_PERIOD_MS);

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] base,
                                                   input logic [TIME_BITS-1:0] add);
    logic [TIME_BITS:0] s;
    s = {1'b0, base} + {1'b0, add};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  logic                 running;
  logic                 mounted_flag;
  logic                 stable_level;
  logic [SAMPLES_W-1:0] mismatch_count;
  logic                 mount_waiting;
  logic [TIME_BITS-1:0] mount_due_time;
  logic [TIME_BITS-1:0] next_sample_time;

  logic                 running_next;
  logic                 mounted_flag_next;
  logic                 stable_level_next;
  logic [SAMPLES_W-1:0] mismatch_count_next;
  logic                 mount_waiting_next;
  logic [TIME_BITS-1:0] mount_due_time_next;
  logic [TIME_BITS-1:0] next_sample_time_next;

  logic [TIME_BITS-1:0] diff;
  logic                 sample_due;
  logic                 small_diff;
  logic                 need_slow;
  logic [RW-1:0]        rem_sel;
  logic [TIME_BITS-1:0] base;
  logic [SAMPLES_W-1:0] cnt_inc;
  logic                 mount_try;

  logic                 mod_start;
  logic                 mod_busy;
  logic                 mod_done;
  logic [RW-1:0]        mod_rem;

  assign diff       = now_ms - next_sample_time;
  assign sample_due = now_ms >= next_sample_time;
  assign small_diff = diff < PERIOD;
  assign need_slow  = (operation == OP_POLL) && running && sample_due && !small_diff;
  assign item_done  = !need_slow || mod_done;
  assign mod_start  = item_valid && need_slow && !mod_busy && !mod_done;
  assign rem_sel    = small_diff ? diff[RW-1:0] : mod_rem;
  assign base       = now_ms - TIME_BITS'(rem_sel);
  assign cnt_inc    = mismatch_count + SAMPLES_W'(1);

  cdml_rem #(
    .TIME_BITS (TIME_BITS),
    .DIVISOR   (SAMPLE_PERIOD_MS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .clear    (fire),
    .dividend (diff),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    running_next          = running;
    mounted_flag_next     = mounted_flag;
    stable_level_next     = stable_level;
    mismatch_count_next   = mismatch_count;
    mount_waiting_next    = mount_waiting;
    mount_due_time_next   = mount_due_time;
    next_sample_time_next = next_sample_time;
    mount_try             = 1'b0;
    result                = '0;

    if (operation == OP_START) begin
      mounted_flag_next     = 1'b0;
      stable_level_next     = 1'b0;
      mismatch_count_next   = '0;
      mount_waiting_next    = 1'b0;
      next_sample_time_next = sat_add(now_ms, PERIOD);
      running_next          = 1'b1;
      if (card_present) begin
        result.mount_attempt = 1'b1;
        if (mount_ok) begin
          mounted_flag_next      = 1'b1;
          result.logging_started = 1'b1;
        end
      end
    end else if (running) begin
      // pending mount fires first
      if (mount_waiting && now_ms >= mount_due_time) begin
        mount_waiting_next = 1'b0;
        mount_try          = !mounted_flag;
        if (mount_try) begin
          result.mount_attempt = 1'b1;
          if (mount_ok) begin
            mounted_flag_next      = 1'b1;
            result.logging_started = 1'b1;
          end
        end
      end
      if (sample_due) begin
        next_sample_time_next = sat_add(base, PERIOD);
        if (card_present == stable_level) begin
          mismatch_count_next = '0;
        end else if (cnt_inc >= cfg.required_samples) begin
          stable_level_next   = card_present;
          mismatch_count_next = '0;
          if (card_present) begin
            mount_waiting_next  = 1'b1;
            mount_due_time_next = sat_add(now_ms,
                                          TIME_BITS'(cfg.insertion_delay_ms));
          end else begin
            mount_waiting_next = 1'b0;
            if (mounted_flag_next) begin
              result.logging_stopped = 1'b1;
              result.unmount_attempt = 1'b1;
              if (unmount_ok) begin
                mounted_flag_next = 1'b0;
              end
            end
          end
        end else begin
          mismatch_count_next = cnt_inc;
        end
      end
    end

    result.is_mounted      = mounted_flag_next;
    result.settled_present = stable_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running          <= 1'b0;
      mounted_flag     <= 1'b0;
      stable_level     <= 1'b0;
      mismatch_count   <= '0;
      mount_waiting    <= 1'b0;
      next_sample_time <= '0;
    end else if (fire) begin
      running          <= running_next;
      mounted_flag     <= mounted_flag_next;
      stable_level     <= stable_level_next;
      mismatch_count   <= mismatch_count_next;
      mount_waiting    <= mount_waiting_next;
      next_sample_time <= next_sample_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mount_due_time <= mount_due_time_next;
    end
  end

endmodule

>>> sv/card_detect_mount_lifecycle_top.sv
// channel | dir  | payload                                                  | handshake
// cmd     | in   | operation, now_ms, card_present, mount_ok, unmount_ok   | valid/ready
// res     | out  | mount_attempt, logging_started/stopped, unmount_attempt, | valid/ready
//         |      | is_mounted, settled_present                              |
// cfg     | in   | apb: insertion_delay_ms @0x0, required_samples @0x4      | psel/penable
//
// one word per cycle unless stalled; words pass the input register, then the result register
// a poll landing a full sample period or more past the next sample time runs the
// remainder unit, and that word stays in the input register until the remainder is done
// synchronous active-high reset clears control and loads register defaults; no clearing pass
// a stalled result register holds; an empty input register still takes a word meanwhile
// depends on cdml_pkg, cdml_cmd_if, cdml_rsp_if, cdml_regs, cdml_lifecycle
module card_detect_mount_lifecycle_top #(
  parameter int TIME_BITS        = 48,
  parameter int SAMPLE_PERIOD_MS = 200
) (
  input  logic                             clk,
  input  logic                             rst,
  cdml_cmd_if.sink                         cmd,
  cdml_rsp_if.source                       res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cdml_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cdml_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cdml_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import cdml_pkg::*;

  cfg_t                 cfg;
  logic                 a_valid;
  logic                 a_operation;
  logic [TIME_BITS-1:0] a_now_ms;
  logic                 a_card_present;
  logic                 a_mount_ok;
  logic                 a_unmount_ok;
  logic                 a_done;
  logic                 a_fire;
  logic                 out_free;
  logic                 res_valid;
  result_t              a_result;
  result_t              res_word;

  assign out_free  = !res_valid || res.ready;
  assign a_fire    = a_valid && a_done && out_free;
  assign cmd.ready = !a_valid || a_fire;

  cdml_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdml_lifecycle #(
    .TIME_BITS        (TIME_BITS),
    .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
  ) u_life (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (a_valid),
    .operation    (a_operation),
    .now_ms       (a_now_ms),
    .card_present (a_card_present),
    .mount_ok     (a_mount_ok),
    .unmount_ok   (a_unmount_ok),
    .cfg          (cfg),
    .fire         (a_fire),
    .item_done    (a_done),
    .result       (a_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        a_valid <= cmd.valid;
      end
      if (a_fire) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      a_operation    <= cmd.operation;
      a_now_ms       <= cmd.now_ms;
      a_card_present <= cmd.card_present;
      a_mount_ok     <= cmd.mount_ok;
      a_unmount_ok   <= cmd.unmount_ok;
    end
    if (a_fire) begin
      res_word <= a_result;
    end
  end

  assign res.valid           = res_valid;
  assign res.mount_attempt   = res_word.mount_attempt;
  assign res.logging_started = res_word.logging_started;
  assign res.logging_stopped = res_word.logging_stopped;
  assign res.unmount_attempt = res_word.unmount_attempt;
  assign res.is_mounted      = res_word.is_mounted;
  assign res.settled_present = res_word.settled_present;

endmodule

>>> sv/cdml_checker.sv
// cdml_checker: port-level assertions on word flow and result consistency
// bound to card_detect_mount_lifecycle_top
module cdml_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic mount_attempt,
  input logic logging_started,
  input logic logging_stopped,
  input logic unmount_attempt,
  input logic is_mounted
);
  logic [1:0] outstanding;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = cmd_valid && cmd_ready;
  assign acc_out = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'(acc_in) - 2'(acc_out);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && cmd_ready)
    else $error("block not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> outstanding != 2'd0)
    else $error("result word without an accepted input word");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more words in flight than the two stages hold");

  a_events: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!logging_started || mount_attempt)
                  && (logging_stopped == unmount_attempt))
    else $error("inconsistent event flags in result word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(is_mounted))
    else $error("stalled result word changed");

endmodule

bind card_detect_mount_lifecycle_top cdml_checker u_cdml_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .mount_attempt   (res.mount_attempt),
  .logging_started (res.logging_started),
  .logging_stopped (res.logging_stopped),
  .unmount_attempt (res.unmount_attempt),
  .is_mounted      (res.is_mounted)
);
